FILE: hdl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is low.
`define SST_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is low.
`define SST_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/sst_pkg.sv
// Types and constants of the sleep timer table.
`default_nettype none

package sst_pkg;

  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned SEC_W     = 12;
  localparam int unsigned NOW_W     = 32;
  localparam int unsigned DL_W      = 33;  // now + 2047 s never wraps
  localparam int unsigned USEC_W    = 20;
  localparam int unsigned PROD_W    = 31;  // 11-bit seconds x 20-bit usec/s
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W     = $clog2(MAX_RESULTS + 1);

  localparam logic [USEC_W-1:0] USEC_PER_SEC = USEC_W'(1000000);

  // input kinds
  localparam logic KIND_SLEEP = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // result kinds
  localparam logic RKIND_STATUS = 1'b0;
  localparam logic RKIND_WAKE   = 1'b1;

  // status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic [SLOT_W-1:0]       slot;
    logic signed [SEC_W-1:0] seconds;
    logic [NOW_W-1:0]        now;
  } sst_in_t;

  typedef struct packed {
    logic              result_kind;
    logic              status;
    logic [SLOT_W-1:0] woken_slot;
    logic              last;
  } sst_out_t;

endpackage

`default_nettype wire

FILE: hdl/sleep_timer_table_unit.sv
// Sleep timer table: per-slot deadline memory with a sequential expiry scan.
`default_nettype none

// Sleep timer table. A transaction is taken at a rising edge with start high
// and busy low. A sleep request (kind 0) gets exactly one status result with
// last set: a negative duration answers invalid, a zero duration or a slot at
// or above SLOTS answers ok and stores nothing, both in the cycle after the
// transaction with busy never raised. A positive duration arms the slot with
// deadline = now + seconds * 1000000; busy stays high through the multiply
// state and the memory write state; the ok result comes the cycle after
// the write. A clock tick (kind 1) walks the deadline memory one entry per
// cycle through its single read port: busy covers a scan state (SLOTS reads,
// a compare behind the last read) and a flush state. Each expired armed
// slot is disarmed and reported as a wake result, in ascending slot order, at
// most 16 per tick; expired slots past that stay armed for a later tick. A
// tick with nothing expired gives no result. Results appear on out_data for
// one cycle with out_valid high; the receiver cannot stall, and the last wake
// result of a tick may appear in the first idle cycle after busy falls.
// Deadline memory has no reset; armed flags reset to zero.
module sleep_timer_table_unit #(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output      logic             busy,
  input  wire sst_pkg::sst_in_t in_data,
  output      logic             out_valid,
  output      sst_pkg::sst_out_t out_data
);

  import sst_pkg::*;

  localparam int unsigned IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned EXT_W  = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_WRITE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t state_r;

  // request registers
  logic [SLOT_W-1:0]  req_slot_r;
  logic [SEC_W-2:0]   req_sec_r;   // magnitude of a positive duration
  logic [NOW_W-1:0]   req_now_r;
  logic [PROD_W-1:0]  prod_r;

  // armed flags, one flop per slot
  logic [SLOTS-1:0]   armed_r;

  // deadline memory, one read and one write port, registered read
  logic [DL_W-1:0]    dl_mem [SLOTS];
  logic [DL_W-1:0]    rd_data_r;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [DL_W-1:0]    wr_data;
  logic [EXT_W-1:0]   slot_ext;

  // scan pipeline: read stage then compare stage
  logic               iss_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               cmp_v_r;
  logic [IDX_W-1:0]   cmp_idx_r;
  logic [CNT_W-1:0]   n_r;
  logic               hold_v_r;
  logic [SLOT_W-1:0]  hold_slot_r;

  logic               hit;
  logic [EXT_W-1:0]   cmp_idx_ext;
  logic [SLOT_W-1:0]  cmp_slot;

  logic               out_valid_r;
  sst_out_t           out_data_r;

  // ---------------------------------------------------------------------
  // Datapath helpers
  // ---------------------------------------------------------------------
  assign slot_ext    = EXT_W'(req_slot_r);
  assign wr_addr     = slot_ext[IDX_W-1:0];
  assign wr_en       = (state_r == ST_WRITE);
  assign wr_data     = DL_W'(req_now_r) + DL_W'(prod_r);

  assign cmp_idx_ext = EXT_W'(cmp_idx_r);
  assign cmp_slot    = cmp_idx_ext[SLOT_W-1:0];

  // Expired and armed, and the per-tick result budget not yet spent.
  assign hit = cmp_v_r && armed_r[cmp_idx_r]
               && (rd_data_r <= DL_W'(req_now_r))
               && (n_r < CNT_W'(MAX_RESULTS));

  // ---------------------------------------------------------------------
  // Deadline memory
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_en) begin
      dl_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (iss_r) begin
      rd_data_r <= dl_mem[rd_idx_r];
    end
  end

  // ---------------------------------------------------------------------
  // Control, armed flags and registered results
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      armed_r     <= '0;
      iss_r       <= 1'b0;
      cmp_v_r     <= 1'b0;
      hold_v_r    <= 1'b0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            req_slot_r <= in_data.slot;
            req_sec_r  <= in_data.seconds[SEC_W-2:0];
            req_now_r  <= in_data.now;
            if (in_data.kind == KIND_TICK) begin
              out_valid_r <= 1'b0;
              rd_idx_r    <= '0;
              iss_r       <= 1'b1;
              cmp_v_r     <= 1'b0;
              hold_v_r    <= 1'b0;
              n_r         <= '0;
              state_r     <= ST_SCAN;
            end else if (in_data.seconds < 0) begin
              out_valid_r            <= 1'b1;
              out_data_r.result_kind <= RKIND_STATUS;
              out_data_r.status      <= STATUS_INVALID;
              out_data_r.woken_slot  <= '0;
              out_data_r.last        <= 1'b1;
            end else if ((in_data.seconds == 0) || (int'(in_data.slot) >= SLOTS)) begin
              // nothing to store
              out_valid_r            <= 1'b1;
              out_data_r.result_kind <= RKIND_STATUS;
              out_data_r.status      <= STATUS_OK;
              out_data_r.woken_slot  <= '0;
              out_data_r.last        <= 1'b1;
            end else begin
              out_valid_r <= 1'b0;
              state_r     <= ST_MUL;
            end
          end else begin
            out_valid_r <= 1'b0;
          end
        end

        ST_MUL: begin
          out_valid_r <= 1'b0;
          prod_r      <= PROD_W'(req_sec_r) * PROD_W'(USEC_PER_SEC);
          state_r     <= ST_WRITE;
        end

        ST_WRITE: begin
          // memory takes wr_data this edge
          armed_r[wr_addr]       <= 1'b1;
          out_valid_r            <= 1'b1;
          out_data_r.result_kind <= RKIND_STATUS;
          out_data_r.status      <= STATUS_OK;
          out_data_r.woken_slot  <= '0;
          out_data_r.last        <= 1'b1;
          state_r                <= ST_IDLE;
        end

        ST_SCAN: begin
          // read stage
          cmp_v_r   <= iss_r;
          cmp_idx_r <= rd_idx_r;
          if (iss_r) begin
            if (rd_idx_r == LAST_IDX) begin
              iss_r <= 1'b0;
            end else begin
              rd_idx_r <= rd_idx_r + 1'b1;
            end
          end
          // compare stage: a hit pushes the held wake out (not last)
          out_valid_r <= hit && hold_v_r;
          if (hit) begin
            armed_r[cmp_idx_r] <= 1'b0;
            n_r                <= n_r + 1'b1;
            hold_v_r           <= 1'b1;
            hold_slot_r        <= cmp_slot;
            if (hold_v_r) begin
              out_data_r.result_kind <= RKIND_WAKE;
              out_data_r.status      <= STATUS_OK;
              out_data_r.woken_slot  <= hold_slot_r;
              out_data_r.last        <= 1'b0;
            end
          end
          if (cmp_v_r && (cmp_idx_r == LAST_IDX)) begin
            state_r <= ST_FLUSH;
          end
        end

        ST_FLUSH: begin
          // the held wake is the final one of this tick
          out_valid_r <= hold_v_r;
          if (hold_v_r) begin
            out_data_r.result_kind <= RKIND_WAKE;
            out_data_r.status      <= STATUS_OK;
            out_data_r.woken_slot  <= hold_slot_r;
            out_data_r.last        <= 1'b1;
          end
          hold_v_r <= 1'b0;
          cmp_v_r  <= 1'b0;
          state_r  <= ST_IDLE;
        end

        default: begin
          out_valid_r <= 1'b0;
          state_r     <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: hdl/sst_checker.sv
// Port-level checker for the sleep timer table, with its bind.
`default_nettype none

`include "assert_macros.svh"

module sst_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire sst_pkg::sst_in_t  in_data,
  input wire logic              out_valid,
  input wire sst_pkg::sst_out_t out_data
);

  import sst_pkg::*;

  // a tick occupies the block; this check does not cover a positive sleep
  `SST_ASSERT_NXT(a_busy_after_work, start && !busy && (in_data.kind == KIND_TICK), busy, "tick transaction did not raise busy")

  // status results are single and final
  `SST_ASSERT_IMP(a_status_last, out_valid && (out_data.result_kind == RKIND_STATUS), out_data.last, "status result without last")

  // wake results never carry an error status
  `SST_ASSERT_IMP(a_wake_ok, out_valid && (out_data.result_kind == RKIND_WAKE), out_data.status == STATUS_OK, "wake result with nonzero status")

  // more wakes pending means the scan is still running
  `SST_ASSERT_IMP(a_more_busy, out_valid && !out_data.last, busy, "non-final wake while idle")

endmodule

bind sleep_timer_table_unit sst_checker u_sst_checker (.*);

`default_nettype wire
